FILE: sv/cbm_pkg.sv
`default_nettype none
package cbm_pkg;

	localparam int unsigned TIMER_W      = 17;
	localparam logic [TIMER_W-1:0] TIMER_RELOAD = TIMER_W'(107520);
	localparam int unsigned ADDR_W       = 16;
	localparam int unsigned DATA_W       = 8;
	localparam int unsigned MEM_ADDR_W   = 19;

	// register index on the config port
	localparam logic CFG_PRG_RAM_PRESENT    = 1'b0;
	localparam logic CFG_OPTION_ROM_PRESENT = 1'b1;

	typedef enum logic [2:0] {
		OP_CPU_RD = 3'd0,
		OP_CPU_WR = 3'd1,
		OP_PPU_RD = 3'd2,
		OP_PPU_WR = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		TGT_NONE       = 3'd0,
		TGT_PRG_RAM    = 3'd1,
		TGT_OPTION_ROM = 3'd2,
		TGT_PRG_ROM    = 3'd3,
		TGT_CHR_ROM    = 3'd4,
		TGT_CIRAM      = 3'd5
	} target_t;

	// mirror modes of the CIRAM address
	localparam logic [1:0] MIR_A10   = 2'd0;
	localparam logic [1:0] MIR_A11   = 2'd1;
	localparam logic [1:0] MIR_PAGE0 = 2'd2;
	localparam logic [1:0] MIR_PAGE1 = 2'd3;

	typedef struct packed {
		logic                  prg_ram_present;
		logic                  option_rom_present;
		logic [TIMER_W-1:0]    option_timer;
		logic [3:0][7:0]       pattern_bank;
		logic [1:0][7:0]       nametable_bank;
		logic [2:0]            prg_bank;
		logic                  option_off;
		logic                  ram_on;
		logic                  nametable_from_rom;
		logic [1:0]            mirror_mode;
	} map_state_t;

	typedef struct packed {
		logic                  valid;
		logic [2:0]            op;
		logic [ADDR_W-1:0]     bus_address;
		logic [DATA_W-1:0]     bus_data;
	} access_t;

	typedef struct packed {
		logic                  has_result;
		target_t               target;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic                  write_enable;
		logic [DATA_W-1:0]     write_data;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic       index;
		logic       data;
	} cfg_wr_t;

endpackage
`default_nettype wire

FILE: sv/cbm_regs.sv
`default_nettype none
module cbm_regs (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cbm_pkg::cfg_wr_t     cfg_wr,
	input  cbm_pkg::access_t     acc,     // valid = item retires this cycle
	output cbm_pkg::map_state_t  st
);

	cbm_pkg::map_state_t st_q;

	logic cpu_wr;
	logic ram_window;
	logic reg_window;

	assign cpu_wr     = acc.valid && (acc.op == cbm_pkg::OP_CPU_WR);
	assign ram_window = (acc.bus_address[15:13] == 3'b011);
	assign reg_window = acc.bus_address[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prg_ram_present    <= 1'b1;
			st_q.option_rom_present <= 1'b0;
			st_q.option_timer       <= '0;
			st_q.pattern_bank       <= '0;
			st_q.nametable_bank[0]  <= 8'h80;
			st_q.nametable_bank[1]  <= 8'h81;
			st_q.prg_bank           <= '0;
			st_q.option_off         <= 1'b1;
			st_q.ram_on             <= 1'b0;
			st_q.nametable_from_rom <= 1'b0;
			st_q.mirror_mode        <= '0;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					cbm_pkg::CFG_PRG_RAM_PRESENT:    st_q.prg_ram_present <= cfg_wr.data;
					cbm_pkg::CFG_OPTION_ROM_PRESENT: st_q.option_rom_present <= cfg_wr.data;
					default: ;
				endcase
			end

			// timer: load on write to RAM window with RAM off, count down on tick
			if (cpu_wr && ram_window && !st_q.ram_on) begin
				st_q.option_timer <= cbm_pkg::TIMER_RELOAD;
			end else if (acc.valid && (acc.op == cbm_pkg::OP_TICK)
					&& (st_q.option_timer != '0)) begin
				st_q.option_timer <= st_q.option_timer - 1'b1;
			end

			if (cpu_wr && reg_window) begin
				case (acc.bus_address[14:12])
					3'h0: st_q.pattern_bank[0] <= acc.bus_data;
					3'h1: st_q.pattern_bank[1] <= acc.bus_data;
					3'h2: st_q.pattern_bank[2] <= acc.bus_data;
					3'h3: st_q.pattern_bank[3] <= acc.bus_data;
					3'h4: st_q.nametable_bank[0] <= acc.bus_data | 8'h80;
					3'h5: st_q.nametable_bank[1] <= acc.bus_data | 8'h80;
					3'h6: begin
						st_q.mirror_mode        <= acc.bus_data[1:0];
						st_q.nametable_from_rom <= acc.bus_data[4];
					end
					default: begin
						st_q.prg_bank   <= acc.bus_data[2:0];
						st_q.option_off <= acc.bus_data[3];
						st_q.ram_on     <= acc.bus_data[4];
					end
				endcase
			end
		end
	end

	assign st = st_q;

endmodule
`default_nettype wire

FILE: sv/cbm_xlate.sv
`default_nettype none
module cbm_xlate (
	input  cbm_pkg::access_t     acc,
	input  cbm_pkg::map_state_t  st,
	output cbm_pkg::result_t     res
);

	logic [13:0] p;
	logic [10:0] c;
	logic [7:0]  nt_bank;
	logic [7:0]  pt_bank;
	logic [2:0]  prg_sel;
	logic [15:0] a;

	assign a = acc.bus_address;
	assign p = a[13:0];

	always_comb begin
		case (st.mirror_mode)
			cbm_pkg::MIR_A10:   c = {p[10], p[9:0]};
			cbm_pkg::MIR_A11:   c = {p[11], p[9:0]};
			cbm_pkg::MIR_PAGE0: c = {1'b0, p[9:0]};
			default:            c = {1'b1, p[9:0]};
		endcase
	end

	assign nt_bank = st.nametable_bank[c[10]];
	assign pt_bank = st.pattern_bank[p[12:11]];
	assign prg_sel = a[14] ? 3'd7 : st.prg_bank;

	always_comb begin
		res              = '0;
		res.target       = cbm_pkg::TGT_NONE;
		case (acc.op)
			cbm_pkg::OP_CPU_RD, cbm_pkg::OP_CPU_WR: begin
				res.has_result = 1'b1;
				if (a[15:13] == 3'b011) begin
					if (st.ram_on && st.prg_ram_present) begin
						res.target       = cbm_pkg::TGT_PRG_RAM;
						res.mem_address  = cbm_pkg::MEM_ADDR_W'(a);
						res.write_enable = (acc.op == cbm_pkg::OP_CPU_WR);
						res.write_data   = res.write_enable ? acc.bus_data : '0;
					end
				end else if (a[15] && (acc.op == cbm_pkg::OP_CPU_RD)) begin
					if (!a[14] && st.option_rom_present && !st.option_off) begin
						if (st.option_timer != '0) begin
							res.target      = cbm_pkg::TGT_OPTION_ROM;
							res.mem_address = cbm_pkg::MEM_ADDR_W'(a[13:0]);
						end
					end else begin
						res.target      = cbm_pkg::TGT_PRG_ROM;
						res.mem_address = cbm_pkg::MEM_ADDR_W'({prg_sel, a[13:0]});
					end
				end
			end
			cbm_pkg::OP_PPU_RD, cbm_pkg::OP_PPU_WR: begin
				res.has_result = 1'b1;
				if (p[13]) begin
					if (!st.nametable_from_rom) begin
						res.target       = cbm_pkg::TGT_CIRAM;
						res.mem_address  = cbm_pkg::MEM_ADDR_W'(c);
						res.write_enable = (acc.op == cbm_pkg::OP_PPU_WR);
						res.write_data   = res.write_enable ? acc.bus_data : '0;
					end else if (acc.op == cbm_pkg::OP_PPU_RD) begin
						res.target      = cbm_pkg::TGT_CHR_ROM;
						res.mem_address = cbm_pkg::MEM_ADDR_W'({nt_bank, c[9:0]});
					end
				end else if (acc.op == cbm_pkg::OP_PPU_RD) begin
					res.target      = cbm_pkg::TGT_CHR_ROM;
					res.mem_address = {pt_bank, p[10:0]};
				end
			end
			default: res.has_result = 1'b0;  // tick and unused codes
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/cartridge_bank_mapper_top.sv
// Bank-switching cartridge mapper. Each beat on s_axis is one bus access
// (tuser = op: CPU read/write, PPU read/write, tick); each CPU or PPU access
// yields exactly one beat on m_axis naming the target memory (tuser) and the
// address inside it, with write enable and data. Ticks and unused op codes yield
// no beat. Target NONE means open bus / ignored write. Input and result are
// registered; one access is taken every cycle, limited only by m_axis
// back-pressure. Banking registers are loaded by CPU writes at 0x8000 and up;
// a CPU write into 0x6000-0x7fff with RAM disabled arms the option-ROM timer,
// which ticks count down. Users write the two cfg registers (0: work RAM
// present, 1: option ROM present) only while idle; the block does not check.
`default_nettype none
module cartridge_bank_mapper_top (
	input  wire         clk,
	input  wire         arst_n,
	// access in
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] bus_data
	input  wire  [2:0]  s_axis_tuser,   // [2:0] op
	// translated access out
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [18:0] mem_address, [19] write_enable,
	                                    // [27:20] write_data, [31:28] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] target
	// config write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire         cfg_data
);

	cbm_pkg::access_t    acc_s1;
	cbm_pkg::access_t    retire;
	cbm_pkg::map_state_t st;
	cbm_pkg::result_t    res;
	cbm_pkg::cfg_wr_t    cfg_wr;
	cbm_pkg::result_t    out_s2;
	logic                out_valid_q;
	logic                adv_s1;

	// Stage 1 retires when its result (if any) has room in the output register.
	assign adv_s1 = acc_s1.valid
		&& (!res.has_result || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !acc_s1.valid || adv_s1;
	assign cfg_ready     = 1'b1;

	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= '0;
		end else if (s_axis_tready) begin
			acc_s1.valid <= s_axis_tvalid;
			if (s_axis_tvalid) begin
				acc_s1.op          <= s_axis_tuser;
				acc_s1.bus_address <= s_axis_tdata[15:0];
				acc_s1.bus_data    <= s_axis_tdata[23:16];
			end
		end
	end

	// state advances with the item that retires
	always_comb begin
		retire       = acc_s1;
		retire.valid = adv_s1;
	end

	cbm_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.acc    (retire),
		.st     (st)
	);

	cbm_xlate u_xlate (
		.acc (acc_s1),
		.st  (st),
		.res (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res.has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.has_result) begin
			out_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_s2.target;
	assign m_axis_tdata  = {4'b0000, out_s2.write_data, out_s2.write_enable,
		out_s2.mem_address};

`ifndef ASSERT_OFF
	a_we_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_s2.write_enable |->
			(out_s2.target == cbm_pkg::TGT_PRG_RAM || out_s2.target == cbm_pkg::TGT_CIRAM))
		else $error("write enable on a read-only target");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc_s1.valid && !adv_s1 |=> acc_s1.valid && $stable(acc_s1.bus_address))
		else $error("stalled access lost");

	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && acc_s1.op == cbm_pkg::OP_TICK && st.option_timer != '0 |=>
			st.option_timer == $past(st.option_timer) - 1'b1)
		else $error("timer tick miscounted");

	a_no_beat_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !res.has_result && !out_valid_q |=> !out_valid_q)
		else $error("beat produced without an access");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_cartridge_bank_mapper_top.sv
`default_nettype none
module tb_cartridge_bank_mapper_top;

	timeunit 1ns;
	timeprecision 1ps;

	// two register stages between s_axis and m_axis
	localparam int LATENCY            = 2;
	localparam int CYCLE_LIMIT        = 1_000_000;
	localparam int SINK_HOLD_CYCLES   = 400;
	localparam int ACCESSES_PER_SEG   = 90;
	localparam int TIMER_TICKS        = 64;

	// op codes the block ignores
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// CPU address map
	localparam logic [15:0] RAM_BASE   = 16'h6000;
	localparam logic [15:0] ROM_BASE   = 16'h8000;
	localparam logic [15:0] FIXED_BASE = 16'hc000;
	localparam logic [2:0]  FIXED_BANK = 3'd7;

	// register pages, CPU address bits 15..12
	localparam logic [3:0] PAGE_PAT0 = 4'h8;
	localparam logic [3:0] PAGE_PAT1 = 4'h9;
	localparam logic [3:0] PAGE_PAT2 = 4'ha;
	localparam logic [3:0] PAGE_PAT3 = 4'hb;
	localparam logic [3:0] PAGE_NT0  = 4'hc;
	localparam logic [3:0] PAGE_NT1  = 4'hd;
	localparam logic [3:0] PAGE_MIR  = 4'he;
	localparam logic [3:0] PAGE_CTRL = 4'hf;

	// control and mirror page data bits
	localparam logic [7:0] CTRL_OPTION_OFF = 8'h08;
	localparam logic [7:0] CTRL_RAM_ON     = 8'h10;
	localparam logic [7:0] MIR_NT_ROM      = 8'h10;

	// one translated access, as seen on m_axis
	typedef struct {
		cbm_pkg::target_t                target;
		logic [cbm_pkg::MEM_ADDR_W-1:0]  mem_address;
		logic                            write_enable;
		logic [cbm_pkg::DATA_W-1:0]      write_data;
	} xlat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [23:0] s_axis_tdata;   // [15:0] bus_address, [23:16] bus_data
	logic [2:0]  s_axis_tuser;   // [2:0] op
	wire         m_axis_tvalid;
	logic        m_axis_tready;
	wire  [31:0] m_axis_tdata;   // [18:0] mem_address, [19] write_enable, [27:20] write_data
	wire  [2:0]  m_axis_tuser;   // [2:0] target
	logic        cfg_valid;
	wire         cfg_ready;
	logic        cfg_index;
	logic        cfg_data;

	cartridge_bank_mapper_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mapper state as the testbench tracks it. Updated at the edge where a beat
	// is accepted on s_axis, so it always matches the order the block sees.
	logic                          ram_present;
	logic                          rom_present;
	logic [cbm_pkg::TIMER_W-1:0]   option_timer;
	logic [7:0]                    pattern_bank [4];
	logic [7:0]                    nametable_bank [2];
	logic [2:0]                    prg_bank;
	logic                          option_off;
	logic                          ram_on;
	logic                          nt_from_rom;
	logic [1:0]                    mirror_mode;

	xlat_t expected_xlat [$];
	xlat_t want;
	int    mismatches = 0;
	int    cycle_count = 0;

	// idle rates in percent; the sink rate is read by the receiver process
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	// long receiver hold: test asks, receiver process serves and counts
	int holds_asked = 0;
	int holds_done  = 0;

	function automatic void reset_model();
		ram_present       = 1'b1;
		rom_present       = 1'b0;
		option_timer      = '0;
		pattern_bank      = '{default: 8'h00};
		nametable_bank[0] = 8'h80;
		nametable_bank[1] = 8'h81;
		prg_bank          = '0;
		option_off        = 1'b1;
		ram_on            = 1'b0;
		nt_from_rom       = 1'b0;
		mirror_mode       = cbm_pkg::MIR_A10;
	endfunction

	// Translate one access and update the tracked state. Returns 1 when the
	// access produces a beat on m_axis (everything but ticks and spare ops).
	function automatic bit translate(input logic [2:0] op, input logic [15:0] a,
			input logic [7:0] d, output xlat_t r);
		logic [13:0] p;
		logic [10:0] c;
		logic [2:0]  bank;
		r.target       = cbm_pkg::TGT_NONE;
		r.mem_address  = '0;
		r.write_enable = 1'b0;
		r.write_data   = '0;
		case (op)
			cbm_pkg::OP_CPU_RD, cbm_pkg::OP_CPU_WR: begin
				if (a < RAM_BASE) begin
					// open bus
				end else if (a < ROM_BASE) begin
					if (!ram_on) begin
						// RAM window with RAM off arms the option ROM timer
						if (op == cbm_pkg::OP_CPU_WR)
							option_timer = cbm_pkg::TIMER_RELOAD;
					end else if (ram_present) begin
						r.target       = cbm_pkg::TGT_PRG_RAM;
						r.mem_address  = cbm_pkg::MEM_ADDR_W'(a);
						r.write_enable = (op == cbm_pkg::OP_CPU_WR);
						r.write_data   = (op == cbm_pkg::OP_CPU_WR) ? d : 8'h00;
					end
				end else if (op == cbm_pkg::OP_CPU_WR) begin
					case (a[15:12])
						PAGE_PAT0: pattern_bank[0] = d;
						PAGE_PAT1: pattern_bank[1] = d;
						PAGE_PAT2: pattern_bank[2] = d;
						PAGE_PAT3: pattern_bank[3] = d;
						PAGE_NT0:  nametable_bank[0] = d | 8'h80;
						PAGE_NT1:  nametable_bank[1] = d | 8'h80;
						PAGE_MIR: begin
							mirror_mode = d[1:0];
							nt_from_rom = d[4];
						end
						default: begin
							prg_bank   = d[2:0];
							option_off = d[3];
							ram_on     = d[4];
						end
					endcase
				end else if (a < FIXED_BASE && rom_present && !option_off) begin
					if (option_timer != 0) begin
						r.target      = cbm_pkg::TGT_OPTION_ROM;
						r.mem_address = cbm_pkg::MEM_ADDR_W'(a[13:0]);
					end
				end else begin
					bank          = (a < FIXED_BASE) ? prg_bank : FIXED_BANK;
					r.target      = cbm_pkg::TGT_PRG_ROM;
					r.mem_address = cbm_pkg::MEM_ADDR_W'({bank, a[13:0]});
				end
				return 1'b1;
			end
			cbm_pkg::OP_PPU_RD, cbm_pkg::OP_PPU_WR: begin
				p = a[13:0];
				if (p[13]) begin
					case (mirror_mode)
						cbm_pkg::MIR_A10:   c = {p[10], p[9:0]};
						cbm_pkg::MIR_A11:   c = {p[11], p[9:0]};
						cbm_pkg::MIR_PAGE0: c = {1'b0, p[9:0]};
						default:            c = {1'b1, p[9:0]};
					endcase
					if (nt_from_rom) begin
						if (op == cbm_pkg::OP_PPU_RD) begin
							r.target      = cbm_pkg::TGT_CHR_ROM;
							r.mem_address = cbm_pkg::MEM_ADDR_W'({nametable_bank[c[10]],
								c[9:0]});
						end
					end else begin
						r.target       = cbm_pkg::TGT_CIRAM;
						r.mem_address  = cbm_pkg::MEM_ADDR_W'(c);
						r.write_enable = (op == cbm_pkg::OP_PPU_WR);
						r.write_data   = (op == cbm_pkg::OP_PPU_WR) ? d : 8'h00;
					end
				end else if (op == cbm_pkg::OP_PPU_RD) begin
					r.target      = cbm_pkg::TGT_CHR_ROM;
					r.mem_address = {pattern_bank[p[12:11]], p[10:0]};
				end
				return 1'b1;
			end
			cbm_pkg::OP_TICK: begin
				if (option_timer != 0)
					option_timer = option_timer - 1'b1;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Receiver: random tready, plus a long hold whenever a test asks for one.
	// The hold is counted here so the sender keeps offering beats meanwhile.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Result checker: every m_axis beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_xlat.size() == 0) begin
				$error("beat with nothing expected: target %0d tdata %h",
					m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_xlat.pop_front();
				if (m_axis_tuser != want.target) begin
					$error("target: expected %0d, got %0d", want.target, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[18:0] != want.mem_address) begin
					$error("mem_address: expected %h, got %h", want.mem_address,
						m_axis_tdata[18:0]);
					mismatches++;
				end
				if (m_axis_tdata[19] != want.write_enable) begin
					$error("write_enable: expected %0d, got %0d", want.write_enable,
						m_axis_tdata[19]);
					mismatches++;
				end
				if (m_axis_tdata[27:20] != want.write_data) begin
					$error("write_data: expected %h, got %h", want.write_data,
						m_axis_tdata[27:20]);
					mismatches++;
				end
				if (m_axis_tdata[31:28] != 4'h0) begin
					$error("tdata pad: expected 0, got %h", m_axis_tdata[31:28]);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one access beat. tvalid is only dropped while idling, so back to
	// back calls keep it high with no glitch. Prediction runs at acceptance.
	task automatic send_access(input logic [2:0] op, input logic [15:0] addr,
			input logic [7:0] data);
		xlat_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {data, addr};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (translate(op, addr, data, r))
			expected_xlat.push_back(r);
	endtask

	// Stop offering, wait for all results, then let the pipe settle.
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_xlat.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Config writes only happen with the block idle.
	task automatic write_cfg(input logic idx, input logic val);
		drain(LATENCY + 2);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == cbm_pkg::CFG_PRG_RAM_PRESENT)
			ram_present = val;
		else
			rom_present = val;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] page, input logic [7:0] data);
		send_access(cbm_pkg::OP_CPU_WR, {page, 12'($urandom)}, data);
	endtask

	// Reset values: open bus, RAM off, fixed/zero banks, nametable banks
	// 0x80/0x81, tick on a zero timer, spare op codes.
	task automatic test_reset_state();
		send_access(cbm_pkg::OP_TICK, 16'h0000, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, 16'h0000, 8'h00);
		send_access(cbm_pkg::OP_CPU_WR, 16'h5fff, 8'hff);
		send_access(cbm_pkg::OP_CPU_RD, RAM_BASE, 8'h00);
		send_access(OP_SPARE_LO, 16'hffff, 8'hff);
		send_access(OP_SPARE_HI, 16'h0000, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, ROM_BASE, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, 16'hffff, 8'h00);
		send_access(cbm_pkg::OP_PPU_RD, 16'h0000, 8'h00);
		send_access(cbm_pkg::OP_PPU_RD, 16'hffff, 8'h00);  // upper bits dropped
		send_access(cbm_pkg::OP_PPU_WR, 16'h2000, 8'hff);
		send_access(cbm_pkg::OP_PPU_WR, 16'h1fff, 8'h55);  // pattern area, no write
		write_reg(PAGE_MIR, MIR_NT_ROM);
		send_access(cbm_pkg::OP_PPU_RD, 16'h2000, 8'h00);
		send_access(cbm_pkg::OP_PPU_RD, 16'h27ff, 8'h00);
		send_access(cbm_pkg::OP_PPU_WR, 16'h2800, 8'haa);  // nametable in ROM, no write
	endtask

	// All banking registers with extreme data, every mirror mode.
	task automatic test_bank_registers();
		logic [7:0] pat [4] = '{8'hff, 8'h00, 8'ha5, 8'h5a};
		for (int i = 0; i < 4; i++)
			write_reg(PAGE_PAT0 + 4'(i), pat[i]);
		for (int i = 0; i < 4; i++)
			send_access(cbm_pkg::OP_PPU_RD, 16'(i * 16'h0800 + 16'h07ff), 8'h00);
		write_reg(PAGE_NT0, 8'h00);
		write_reg(PAGE_NT1, 8'h7f);
		for (int m = 0; m < 4; m++) begin
			write_reg(PAGE_MIR, 8'(m) | (m[0] ? MIR_NT_ROM : 8'h00));
			send_access(cbm_pkg::OP_PPU_RD, 16'h2c00 + 16'($urandom_range(16'h03ff)),
				8'h00);
			send_access(cbm_pkg::OP_PPU_WR, 16'h3400 + 16'($urandom_range(16'h03ff)),
				8'h3c);
		end
		write_reg(PAGE_CTRL, 8'hff & ~CTRL_RAM_ON);
		send_access(cbm_pkg::OP_CPU_RD, 16'hbfff, 8'h00);
		write_reg(PAGE_CTRL, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, 16'hbfff, 8'h00);
	endtask

	// Option ROM: read with the timer at zero, arming, reads while it runs,
	// countdown ticks, option ROM switched off, then work RAM present and absent.
	task automatic test_option_timer();
		write_cfg(cbm_pkg::CFG_OPTION_ROM_PRESENT, 1'b1);
		write_reg(PAGE_CTRL, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, 16'h9234, 8'h00);  // timer at zero
		send_access(cbm_pkg::OP_TICK, 16'h0000, 8'h00);    // stays at zero
		send_access(cbm_pkg::OP_CPU_RD, 16'h9234, 8'h00);
		send_access(cbm_pkg::OP_CPU_WR, 16'h7fff, 8'h00);  // arms the timer
		send_access(cbm_pkg::OP_CPU_RD, ROM_BASE, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, 16'hbfff, 8'h00);
		send_access(cbm_pkg::OP_CPU_RD, FIXED_BASE, 8'h00);
		repeat (TIMER_TICKS)
			send_access(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
		send_access(cbm_pkg::OP_CPU_RD, 16'h9234, 8'h00);  // still running
		write_reg(PAGE_CTRL, CTRL_OPTION_OFF);
		send_access(cbm_pkg::OP_CPU_RD, 16'h9234, 8'h00);
		write_reg(PAGE_CTRL, CTRL_RAM_ON | 8'h07);
		send_access(cbm_pkg::OP_CPU_WR, 16'h7fff, 8'haa);
		send_access(cbm_pkg::OP_CPU_RD, 16'h6123, 8'h00);
		write_cfg(cbm_pkg::CFG_PRG_RAM_PRESENT, 1'b0);
		send_access(cbm_pkg::OP_CPU_RD, RAM_BASE, 8'h00);
		send_access(cbm_pkg::OP_CPU_WR, RAM_BASE, 8'h11);
		write_cfg(cbm_pkg::CFG_PRG_RAM_PRESENT, 1'b1);
	endtask

	// Receiver stalls for a long stretch while the sender keeps offering,
	// so the output fills and s_axis_tready must drop.
	task automatic test_output_stall();
		drain(LATENCY + 2);
		src_idle_pct = 0;
		holds_asked++;
		repeat (40)
			send_access(cbm_pkg::OP_CPU_RD, 16'($urandom_range(ROM_BASE, 16'hffff)), 8'h00);
		while (holds_done != holds_asked)
			send_access(cbm_pkg::OP_PPU_RD, 16'($urandom), 8'h00);
	endtask

	function automatic logic [15:0] cpu_address(input int region);
		case (region)
			0: return 16'($urandom_range(RAM_BASE - 1));
			1: return 16'($urandom_range(RAM_BASE, ROM_BASE - 1));
			2: return 16'($urandom_range(ROM_BASE, FIXED_BASE - 1));
			3: return 16'($urandom_range(FIXED_BASE, 16'hffff));
			default: return 16'($urandom);
		endcase
	endfunction

	// One random access. Returns 0 for spare op codes, which do not count.
	task automatic send_random_access(output bit counted);
		int pick;
		int w;
		pick    = $urandom_range(99);
		counted = 1'b1;
		if (pick < 25) begin
			send_access(cbm_pkg::OP_CPU_RD, cpu_address($urandom_range(4)), 8'($urandom));
		end else if (pick < 45) begin
			w = $urandom_range(99);
			if (w < 35)
				send_access(cbm_pkg::OP_CPU_WR, cpu_address(1), 8'($urandom));
			else if (w < 80)
				send_access(cbm_pkg::OP_CPU_WR, cpu_address($urandom_range(2, 3)),
					8'($urandom));
			else
				send_access(cbm_pkg::OP_CPU_WR, cpu_address($urandom_range(0, 4)),
					8'($urandom));
		end else if (pick < 65) begin
			send_access(cbm_pkg::OP_PPU_RD, 16'($urandom), 8'($urandom));
		end else if (pick < 80) begin
			send_access(cbm_pkg::OP_PPU_WR, 16'($urandom), 8'($urandom));
		end else if (pick < 95) begin
			send_access(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
		end else begin
			send_access(OP_SPARE_LO + 3'($urandom_range(2)), 16'($urandom), 8'($urandom));
			counted = 1'b0;
		end
	endtask

	// Random traffic under one idle profile, across all four config settings.
	task automatic test_random_traffic(input int src_pct, input int sink_pct);
		bit counted;
		int sent;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		for (int seg = 0; seg < 4; seg++) begin
			write_cfg(cbm_pkg::CFG_PRG_RAM_PRESENT, seg[0]);
			write_cfg(cbm_pkg::CFG_OPTION_ROM_PRESENT, seg[1]);
			sent = 0;
			while (sent < ACCESSES_PER_SEG) begin
				send_random_access(counted);
				sent += int'(counted);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = cbm_pkg::OP_CPU_RD;
		cfg_valid     = 1'b0;
		cfg_index     = cbm_pkg::CFG_PRG_RAM_PRESENT;
		cfg_data      = 1'b0;
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 15;
		sink_idle_pct = 85;
		test_reset_state();
		test_bank_registers();
		test_option_timer();
		test_output_stall();
		test_random_traffic(15, 85);
		test_random_traffic(85, 15);
		test_random_traffic(0, 0);

		drain(LATENCY + 10);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

FILE: cartridge_bank_mapper_top.f
sv/cbm_pkg.sv
sv/cbm_regs.sv
sv/cbm_xlate.sv
sv/cartridge_bank_mapper_top.sv
tb/tb_cartridge_bank_mapper_top.sv
